// File: rtl/ptm_pkg.sv
package ptm_pkg;

  localparam int unsigned MAX_TABLES        = 8;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned FRAME_W           = 40;
  localparam int unsigned TARGET_W          = 27;
  localparam int unsigned COUNT_W           = 4;
  localparam int unsigned LIMIT_W           = 4;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = FRAME_W;

  localparam logic [COUNT_W-1:0]   COUNT_MAX       = 4'd15;
  localparam logic [COUNT_W-1:0]   COUNT_RESET     = 4'd1;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_AREA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_MAPPED  = 2'd0,
    STATUS_ALREADY = 2'd1,
    STATUS_NO_MEM  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  typedef enum logic [1:0] {
    LVL_PML4,
    LVL_PDPT,
    LVL_PD
  } level_e;

  typedef enum logic {
    OP_FOLLOW,
    OP_LINK
  } unit_op_e;

  // stored entry: only the present bit and the 40-bit frame field matter
  // downstream; tag marks the table epoch the entry was written in
  typedef struct packed {
    logic               tag;
    logic               present;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    unit_op_e           op;
    logic [FRAME_W-1:0] entry_frame;
    logic [FRAME_W-1:0] area;
    logic [COUNT_W-1:0] count;
  } unit_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] sum;
    logic               in_range;
  } unit_rsp_t;

endpackage

// File: rtl/page_table_2m_mapper.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------
// item in  | start_i & !busy_o    | target_frame_i
// result   | done_o (one cycle)   | status_o, tables_used_o
// config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// From acceptance to the done_o strobe an item runs three dependent
// read/evaluate steps, one per level, sharing one 40-bit add/compare unit;
// a stale link or a failed allocation ends the item early, at PML4 or at PDPT.
// busy_o drops in the done_o cycle, so the next item can start there.
// After reset a clearing pass zeroes all MAX_TABLES*512 memory entries;
// busy_o stays high meanwhile, config writes are taken; done_o is never held off.
module page_table_2m_mapper #(
  parameter int unsigned MAX_TABLES = ptm_pkg::MAX_TABLES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ptm_pkg::TARGET_W-1:0]     target_frame_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [ptm_pkg::STATUS_W-1:0]     status_o,
  output logic [ptm_pkg::COUNT_W-1:0]      tables_used_o,
  input  logic                             cfg_we_i,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned OBJ_W  = $clog2(MAX_TABLES);
  localparam int unsigned IDX_W  = ptm_pkg::IDX_W;
  localparam int unsigned ADDR_W = OBJ_W + IDX_W;

  ptm_pkg::state_e               state_q, state_d;
  ptm_pkg::level_e               lvl_q, lvl_d;
  logic [OBJ_W-1:0]              obj_q, obj_d;
  logic [ptm_pkg::TARGET_W-1:0]  target_q, target_d;
  logic [ptm_pkg::COUNT_W-1:0]   count_q, count_d;
  logic [MAX_TABLES-1:0]         phase_q, phase_d;
  ptm_pkg::status_e              status_q, status_d;
  logic                          done_q, done_d;
  logic [ptm_pkg::FRAME_W-1:0]   area_q;
  logic [ptm_pkg::LIMIT_W-1:0]   limit_q;

  logic                          clear_done;
  logic                          accept;
  logic [IDX_W-1:0]              idx_cur;
  logic [OBJ_W-1:0]              new_obj;
  logic                          alloc_ok;
  logic                          present;
  logic                          wr_en;
  ptm_pkg::entry_t               wr_data;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  ptm_pkg::entry_t               rd_data;
  ptm_pkg::unit_req_t            unit_req;
  ptm_pkg::unit_rsp_t            unit_rsp;

  ptm_store #(
    .MAX_TABLES(MAX_TABLES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_done_o(clear_done),
    .wr_en_i     (wr_en),
    .wr_addr_i   ({obj_q, idx_cur}),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  ptm_addr_unit #(
    .MAX_TABLES(MAX_TABLES)
  ) u_unit (
    .req_i(unit_req),
    .rsp_o(unit_rsp)
  );

  assign busy_o        = (state_q != ptm_pkg::ST_IDLE) || !clear_done;
  assign accept        = start_i && !busy_o;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign tables_used_o = count_q;

  always_comb begin
    unique case (lvl_q)
      ptm_pkg::LVL_PML4: idx_cur = target_q[26:18];
      ptm_pkg::LVL_PDPT: idx_cur = target_q[17:9];
      ptm_pkg::LVL_PD:   idx_cur = target_q[8:0];
      default:           idx_cur = '0;
    endcase
  end

  assign new_obj  = OBJ_W'(count_q);
  assign alloc_ok = (count_q < limit_q) && (32'(count_q) < MAX_TABLES);
  // entry counts only if written in the current epoch of its table
  assign present  = rd_data.present && (rd_data.tag == phase_q[obj_q]);

  assign unit_req.op          = present ? ptm_pkg::OP_FOLLOW : ptm_pkg::OP_LINK;
  assign unit_req.entry_frame = rd_data.frame;
  assign unit_req.area        = area_q;
  assign unit_req.count       = count_q;

  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    obj_d    = obj_q;
    target_d = target_q;
    count_d  = count_q;
    phase_d  = phase_q;
    status_d = status_q;
    done_d   = 1'b0;
    wr_en    = 1'b0;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = {obj_q, idx_cur};

    unique case (state_q)
      ptm_pkg::ST_IDLE: begin
        if (accept) begin
          // PML4 read goes out in the accept cycle
          rd_en    = 1'b1;
          rd_addr  = {{OBJ_W{1'b0}}, target_frame_i[26:18]};
          target_d = target_frame_i;
          obj_d    = '0;
          lvl_d    = ptm_pkg::LVL_PML4;
          state_d  = ptm_pkg::ST_EVAL;
        end
      end
      ptm_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = ptm_pkg::ST_EVAL;
      end
      ptm_pkg::ST_EVAL: begin
        if (lvl_q == ptm_pkg::LVL_PD) begin
          done_d  = 1'b1;
          state_d = ptm_pkg::ST_IDLE;
          if (present) begin
            status_d = ptm_pkg::STATUS_ALREADY;
          end else begin
            status_d        = ptm_pkg::STATUS_MAPPED;
            wr_en           = 1'b1;
            wr_data.tag     = phase_q[obj_q];
            wr_data.present = 1'b1;
            wr_data.frame   = {4'b0, target_q, 9'b0};
          end
        end else if (present) begin
          if (unit_rsp.in_range) begin
            obj_d   = unit_rsp.sum[OBJ_W-1:0];
            lvl_d   = (lvl_q == ptm_pkg::LVL_PML4) ? ptm_pkg::LVL_PDPT : ptm_pkg::LVL_PD;
            state_d = ptm_pkg::ST_READ;
          end else begin
            // stale link
            status_d = ptm_pkg::STATUS_NO_MEM;
            done_d   = 1'b1;
            state_d  = ptm_pkg::ST_IDLE;
          end
        end else begin
          if (count_q != ptm_pkg::COUNT_MAX) begin
            count_d = count_q + 1'b1;
          end
          if (alloc_ok) begin
            // new epoch clears the table; link may land in it if obj == new
            phase_d[new_obj] = 1'b1;
            wr_en            = 1'b1;
            wr_data.tag      = phase_d[obj_q];
            wr_data.present  = 1'b1;
            wr_data.frame    = unit_rsp.sum;
            obj_d            = new_obj;
            lvl_d   = (lvl_q == ptm_pkg::LVL_PML4) ? ptm_pkg::LVL_PDPT : ptm_pkg::LVL_PD;
            state_d = ptm_pkg::ST_READ;
          end else begin
            status_d = ptm_pkg::STATUS_NO_MEM;
            done_d   = 1'b1;
            state_d  = ptm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ptm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ptm_pkg::ST_IDLE;
      count_q  <= ptm_pkg::COUNT_RESET;
      phase_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ptm_pkg::STATUS_MAPPED;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      phase_q  <= phase_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    obj_q    <= obj_d;
    target_q <= target_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q  <= '0;
      limit_q <= ptm_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == ptm_pkg::CFG_TABLE_AREA) begin
        area_q <= cfg_wdata_i;
      end else if (cfg_idx_i == ptm_pkg::CFG_TABLE_LIMIT) begin
        limit_q <= cfg_wdata_i[ptm_pkg::LIMIT_W-1:0];
      end else begin
        area_q <= area_q;
      end
    end
  end

endmodule

// File: rtl/ptm_store.sv
module ptm_store #(
  parameter int unsigned MAX_TABLES = ptm_pkg::MAX_TABLES,
  localparam int unsigned OBJ_W     = $clog2(MAX_TABLES),
  localparam int unsigned ADDR_W    = OBJ_W + ptm_pkg::IDX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                clear_done_o,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  ptm_pkg::entry_t     wr_data_i,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output ptm_pkg::entry_t     rd_data_o
);

  localparam int unsigned DEPTH = MAX_TABLES * ptm_pkg::ENTRIES_PER_TABLE;

  ptm_pkg::entry_t mem_q [DEPTH];
  ptm_pkg::entry_t rd_q;
  logic [ADDR_W:0] clr_q, clr_d;
  logic            clear_done;
  logic            we;
  logic [ADDR_W-1:0] waddr;
  ptm_pkg::entry_t wdata;

  assign clear_done = (clr_q == (ADDR_W+1)'(DEPTH));
  assign clr_d      = clear_done ? clr_q : clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // clearing pass after reset owns the write port
  assign we    = !clear_done || wr_en_i;
  assign waddr = clear_done ? wr_addr_i : clr_q[ADDR_W-1:0];
  assign wdata = clear_done ? wr_data_i : '0;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign clear_done_o = clear_done;
  assign rd_data_o    = rd_q;

endmodule

// File: rtl/ptm_addr_unit.sv
module ptm_addr_unit #(
  parameter int unsigned MAX_TABLES = ptm_pkg::MAX_TABLES
) (
  input  ptm_pkg::unit_req_t req_i,
  output ptm_pkg::unit_rsp_t rsp_o
);

  logic [ptm_pkg::FRAME_W-1:0] op_a, op_b;
  logic                        cin;
  logic [ptm_pkg::FRAME_W-1:0] sum;

  // follow: entry_frame - area ; link: area + count
  always_comb begin
    unique case (req_i.op)
      ptm_pkg::OP_FOLLOW: begin
        op_a = req_i.entry_frame;
        op_b = ~req_i.area;
        cin  = 1'b1;
      end
      ptm_pkg::OP_LINK: begin
        op_a = req_i.area;
        op_b = ptm_pkg::FRAME_W'(req_i.count);
        cin  = 1'b0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        cin  = 1'b0;
      end
    endcase
  end

  assign sum            = op_a + op_b + ptm_pkg::FRAME_W'(cin);
  assign rsp_o.sum      = sum;
  assign rsp_o.in_range = (sum < ptm_pkg::FRAME_W'(MAX_TABLES));

endmodule

// File: tb/page_map_checker.sv
module page_map_checker
  import ptm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [TARGET_W-1:0]   target_frame_i,
  input  logic                  done_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [COUNT_W-1:0]    tables_used_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           fail_cnt_o,
  output int unsigned           owed_o
);

  localparam logic [63:0] ENTRY_FRAME_FIELD = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] PTE_LINK_BITS = 64'h3;   // present | writable
  localparam logic [63:0] PTE_LEAF_BITS = 64'h83;  // present | writable | page size
  localparam int unsigned STORE_DEPTH   = MAX_TABLES * ENTRIES_PER_TABLE;

  typedef struct {
    status_e            status;
    logic [COUNT_W-1:0] used;
  } map_result_t;

  logic [63:0]        pt_mem [STORE_DEPTH];
  logic [COUNT_W-1:0] alloc_cnt;
  logic [FRAME_W-1:0] area_frame;
  logic [LIMIT_W-1:0] table_cap;
  map_result_t        map_results_q[$];
  int unsigned        mismatch_cnt;

  function automatic int unsigned slot(int unsigned obj, logic [IDX_W-1:0] idx);
    return obj * ENTRIES_PER_TABLE + idx;
  endfunction

  // bump allocation; the count moves on even when the attempt fails
  function automatic logic claim_table(output int unsigned obj);
    int unsigned n;
    n   = 32'(alloc_cnt);
    obj = 0;
    if (alloc_cnt < COUNT_MAX) alloc_cnt = alloc_cnt + 1'b1;
    if (n >= table_cap || n >= MAX_TABLES) return 1'b0;
    for (int i = 0; i < ENTRIES_PER_TABLE; i++) pt_mem[n * ENTRIES_PER_TABLE + i] = '0;
    obj = n;
    return 1'b1;
  endfunction

  function automatic logic descend_level(input int unsigned obj, input logic [IDX_W-1:0] idx,
                                         output int unsigned next);
    logic [63:0]        e;
    logic [FRAME_W-1:0] obj_off;
    logic [FRAME_W-1:0] link_frame;
    int unsigned        fresh;
    e    = pt_mem[slot(obj, idx)];
    next = 0;
    if (e[0]) begin
      // link is resolved against the area register as it is now
      obj_off = e[51:12] - area_frame;
      if (obj_off >= MAX_TABLES) return 1'b0;
      next = 32'(obj_off);
      return 1'b1;
    end
    if (!claim_table(fresh)) return 1'b0;
    link_frame = area_frame + FRAME_W'(fresh);
    pt_mem[slot(obj, idx)] = PTE_LINK_BITS | ({12'h0, link_frame, 12'h0} & ENTRY_FRAME_FIELD);
    next = fresh;
    return 1'b1;
  endfunction

  function automatic status_e walk_and_map(logic [TARGET_W-1:0] frame);
    int unsigned pdpt;
    int unsigned pd;
    int unsigned leaf;
    if (!descend_level(0, frame[26:18], pdpt)) return STATUS_NO_MEM;
    if (!descend_level(pdpt, frame[17:9], pd)) return STATUS_NO_MEM;
    leaf = slot(pd, frame[8:0]);
    if (pt_mem[leaf][0]) return STATUS_ALREADY;
    pt_mem[leaf] = PTE_LEAF_BITS | ({16'h0, frame, 21'h0} & ENTRY_FRAME_FIELD);
    return STATUS_MAPPED;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t exp_res;
    map_result_t new_res;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) pt_mem[i] = '0;
      alloc_cnt  = COUNT_RESET;
      area_frame = '0;
      table_cap  = LIMIT_RESET;
      map_results_q.delete();
      mismatch_cnt = 0;
      fail_cnt_o <= 0;
      owed_o     <= 0;
    end else begin
      if (done_i) begin
        if (map_results_q.size() == 0) begin
          $display("%0t: result with no transaction outstanding: status %0d tables_used %0d",
                   $time, status_i, tables_used_i);
          mismatch_cnt++;
        end else begin
          exp_res = map_results_q.pop_front();
          if (status_i !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_res.status, status_i);
            mismatch_cnt++;
          end
          if (tables_used_i !== exp_res.used) begin
            $display("%0t: tables_used mismatch: expected %0d actual %0d",
                     $time, exp_res.used, tables_used_i);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TABLE_AREA) area_frame = cfg_wdata_i;
        else if (cfg_idx_i == CFG_TABLE_LIMIT) table_cap = cfg_wdata_i[LIMIT_W-1:0];
      end
      if (start_i && !busy_i) begin
        new_res.status = walk_and_map(target_frame_i);
        new_res.used   = alloc_cnt;
        map_results_q.push_back(new_res);
      end
      fail_cnt_o <= mismatch_cnt;
      owed_o     <= map_results_q.size();
    end
  end

endmodule

// File: tb/tb_page_table_2m_mapper.sv
module tb_page_table_2m_mapper;
  import ptm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;
  localparam logic [FRAME_W-1:0]   AREA_TOP      = '1;
  localparam int unsigned          SETTLE_CYCLES = 12;
  localparam int unsigned          PHASES        = 6;
  localparam int unsigned          PHASE_ITEMS   = 100;
  localparam int unsigned          STALE_PHASE   = 3;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start_i        = 1'b0;
  logic [TARGET_W-1:0]   target_frame_i = '0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [COUNT_W-1:0]    tables_used_o;
  int unsigned           fail_cnt;
  int unsigned           owed;
  bit                    gaps_on;

  // PML4/PDPT index pairs whose tables get built by the directed part
  logic [17:0] hot_prefix [3] = '{18'h00000, 18'h3ffff, {9'h0aa, 9'h155}};

  page_table_2m_mapper DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .target_frame_i (target_frame_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .status_o       (status_o),
    .tables_used_o  (tables_used_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  page_map_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .target_frame_i (target_frame_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .tables_used_i  (tables_used_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_cnt_o     (fail_cnt),
    .owed_o         (owed)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 500000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [TARGET_W-1:0] mk_frame(logic [8:0] pml4, logic [8:0] pdpt,
                                                  logic [8:0] pd);
    return {pml4, pdpt, pd};
  endfunction

  // limit value with random junk in the unused upper bits
  function automatic logic [CFG_DATA_W-1:0] limit_word(logic [LIMIT_W-1:0] cap);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    w[LIMIT_W-1:0] = cap;
    return w[CFG_DATA_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[CFG_DATA_W-1:0];
  endfunction

  function automatic logic [TARGET_W-1:0] random_frame();
    logic [17:0]         pre;
    logic [8:0]          low;
    logic [31:0]         raw;
    raw = $urandom();
    if ($urandom_range(0, 9) < 2) return raw[TARGET_W-1:0];
    pre = hot_prefix[2'($urandom_range(0, 2))];
    // a narrow leaf index range makes repeats likely
    if ($urandom_range(0, 1)) low = raw[8:0];
    else low = 9'($urandom_range(0, 15));
    return {pre, low};
  endfunction

  task automatic push_frame(input logic [TARGET_W-1:0] frame);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) gap = 0;
      else if (pick < 18) gap = $urandom_range(1, 6);
      else gap = $urandom_range(10, 60);
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    target_frame_i <= frame;
    do @(posedge clk_i); while (busy_o);
  endtask

  // drain every outstanding transaction before touching the registers
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (owed != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    gaps_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero limit: every allocation fails, the count still moves
    write_reg(CFG_TABLE_LIMIT, limit_word(4'd0));
    write_reg(CFG_TABLE_AREA, '0);
    push_frame(mk_frame(9'h000, 9'h000, 9'h000));
    push_frame(mk_frame(9'h1ff, 9'h1ff, 9'h1ff));
    settle();

    // area at the top of the frame space so object links wrap around
    write_reg(CFG_TABLE_AREA, AREA_TOP);
    write_reg(CFG_TABLE_LIMIT, limit_word(4'd15));
    push_frame(mk_frame(9'h000, 9'h000, 9'h000));
    push_frame(mk_frame(9'h000, 9'h000, 9'h000));
    push_frame(mk_frame(9'h000, 9'h000, 9'h1ff));
    push_frame(mk_frame(9'h1ff, 9'h1ff, 9'h1ff));
    // PDPT fits, PD runs out; the upper link must stay
    push_frame(mk_frame(9'h0aa, 9'h155, 9'h003));
    push_frame(mk_frame(9'h0aa, 9'h155, 9'h003));
    push_frame(mk_frame(9'h000, 9'h000, 9'h155));
    push_frame(mk_frame(9'h1ff, 9'h1ff, 9'h1ff));
    // drive the allocation count into saturation
    for (int i = 1; i <= 7; i++) push_frame(mk_frame(9'(i), 9'h000, 9'h000));
    settle();

    // moved area: existing links no longer resolve
    write_reg(CFG_TABLE_AREA, random_word());
    write_reg(CFG_SPARE_A, random_word());
    write_reg(CFG_SPARE_B, random_word());
    push_frame(mk_frame(9'h000, 9'h000, 9'h009));
    push_frame(mk_frame(9'h1ff, 9'h1ff, 9'h000));
    push_frame(mk_frame(9'h000, 9'h000, 9'h000));
    settle();

    write_reg(CFG_TABLE_AREA, AREA_TOP);
    write_reg(CFG_TABLE_LIMIT, limit_word(4'd1));
    push_frame(mk_frame(9'h000, 9'h000, 9'h000));
    push_frame(mk_frame(9'h000, 9'h000, 9'h0f0));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(CFG_TABLE_LIMIT, limit_word(LIMIT_W'($urandom_range(0, 15))));
      if (ph == STALE_PHASE) write_reg(CFG_TABLE_AREA, random_word());
      else write_reg(CFG_TABLE_AREA, AREA_TOP);
      if (ph == 2) write_reg(CFG_SPARE_B, random_word());
      gaps_on = (ph != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) push_frame(random_frame());
    end
    settle();

    if (fail_cnt == 0 && owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
